// ----- design/csv_record_tokenizer_core_macros.svh -----
// Assertion macros used by the CSV tokenizer parser module
`ifndef CSV_RECORD_TOKENIZER_CORE_MACROS_SVH
`define CSV_RECORD_TOKENIZER_CORE_MACROS_SVH

// check a condition at every clock edge outside reset
`define CSV_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// check a consequent in the same cycle as its antecedent
`define CSV_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// check a consequent in the cycle after its antecedent
`define CSV_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/csv_rt_pkg.sv -----
// Types and constants of the CSV record tokenizer
package csv_rt_pkg;

  typedef struct packed {
    logic       kind;
    logic [7:0] byte_in;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]         result_kind;
    logic [6:0]         content_byte;
    logic [1:0]         field_type;
    logic signed [63:0] int_value;
    logic [15:0]        field_index;
    logic               last_in_record;
    logic               record_dropped;
    logic [2:0]         error_code;
    logic [31:0]        line_number;
  } out_beat_t;

  typedef struct packed {
    logic       eof;
    logic       non_ascii;
    logic [6:0] ch;
    logic       is_ws;
    logic       is_dig;
    logic       hex_ok;
    logic [3:0] hex_val;
    logic       is_comma;
    logic       is_cr;
    logic       is_lf;
    logic       is_quote;
    logic       is_plus;
    logic       is_minus;
    logic       is_x;
    logic       is_zero;
  } cls_t;

  typedef enum logic [1:0] {
    RK_CONTENT = 2'd0,
    RK_FIELD   = 2'd1,
    RK_STREAM  = 2'd2,
    RK_ERROR   = 2'd3
  } rkind_e;

  typedef enum logic [1:0] {
    FT_EMPTY = 2'd0,
    FT_INT   = 2'd1,
    FT_TEXT  = 2'd2
  } ftype_e;

  typedef enum logic [2:0] {
    ERR_NON_ASCII    = 3'd0,
    ERR_EOF_QUOTE    = 3'd1,
    ERR_CR_NO_LF     = 3'd2,
    ERR_STRAY        = 3'd3,
    ERR_LEN_MISMATCH = 3'd4,
    ERR_KEY_NOT_INT  = 3'd5,
    ERR_TOO_MANY     = 3'd6
  } err_e;

  typedef enum logic [2:0] {
    PH_REC   = 3'd0,
    PH_FLD   = 3'd1,
    PH_UNQ   = 3'd2,
    PH_QUO   = 3'd3,
    PH_QSEEN = 3'd4,
    PH_CR    = 3'd5,
    PH_DONE  = 3'd6
  } phase_e;

  typedef enum logic [2:0] {
    NP_LEAD  = 3'd0,
    NP_SIGN  = 3'd1,
    NP_ZERO  = 3'd2,
    NP_HEXP  = 3'd3,
    NP_DEC   = 3'd4,
    NP_HEX   = 3'd5,
    NP_TRAIL = 3'd6,
    NP_BAD   = 3'd7
  } nphase_e;

  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChX     = 8'h78;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChVt    = 8'h0B;
  localparam logic [7:0] ChFf    = 8'h0C;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowF  = 8'h66;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpF   = 8'h46;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);

endpackage

// ----- design/csv_rt_front.sv -----
// Input side: accepts byte beats and classifies them for the parser
module csv_rt_front (
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  csv_rt_pkg::in_beat_t in_data_i,
  input  logic                 q_full_i,
  output logic                 q_push_o,
  output csv_rt_pkg::cls_t     q_data_o
);
  import csv_rt_pkg::*;

  logic [7:0] b;
  logic       lo_hex;
  logic       up_hex;

  assign b          = in_data_i.byte_in;
  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    lo_hex             = (b >= ChLowA) && (b <= ChLowF);
    up_hex             = (b >= ChUpA) && (b <= ChUpF);
    q_data_o           = '0;
    q_data_o.eof       = in_data_i.kind;
    q_data_o.non_ascii = b[7];
    q_data_o.ch        = b[6:0];
    q_data_o.is_ws     = (b == ChSpace) || (b == ChTab) || (b == ChVt) || (b == ChFf);
    q_data_o.is_dig    = (b >= ChZero) && (b <= ChNine);
    q_data_o.hex_ok    = q_data_o.is_dig || lo_hex || up_hex;
    if (lo_hex) begin
      q_data_o.hex_val = 4'(b - ChLowA + 8'd10);
    end else if (up_hex) begin
      q_data_o.hex_val = 4'(b - ChUpA + 8'd10);
    end else begin
      q_data_o.hex_val = 4'(b - ChZero);
    end
    q_data_o.is_comma  = (b == ChComma);
    q_data_o.is_cr     = (b == ChCr);
    q_data_o.is_lf     = (b == ChLf);
    q_data_o.is_quote  = (b == ChQuote);
    q_data_o.is_plus   = (b == ChPlus);
    q_data_o.is_minus  = (b == ChMinus);
    q_data_o.is_x      = (b == ChX);
    q_data_o.is_zero   = (b == ChZero);
  end

endmodule

// ----- design/csv_rt_queue.sv -----
// Short queue of classified beats between front and back
module csv_rt_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  csv_rt_pkg::cls_t data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output csv_rt_pkg::cls_t data_o
);
  import csv_rt_pkg::*;

  cls_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, wr_d;
  logic [QPtrW-1:0] rd_q, rd_d;
  logic [QPtrW:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == (QPtrW+1)'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == QPtrW'(QDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == QPtrW'(QDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ----- design/csv_rt_back.sv -----
// Parser: field and number state, record checks and the result register
`include "csv_record_tokenizer_core_macros.svh"

module csv_rt_back #(
  parameter int unsigned MAX_FIELDS = 65535
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  csv_rt_pkg::cls_t      q_data_i,
  output logic                  q_pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output csv_rt_pkg::out_beat_t out_data_o
);
  import csv_rt_pkg::*;

  localparam logic [16:0] MaxFields = 17'(MAX_FIELDS);

  phase_e      phase_q, phase_d;
  nphase_e     nph_q, nph_d;
  logic [63:0] acc_q, acc_d;
  logic        neg_q, neg_d;
  logic        ovf_q, ovf_d;
  logic [15:0] fc_q, fc_d;
  logic        exp_set_q, exp_set_d;
  logic [15:0] exp_q, exp_d;
  logic        key_q, key_d;
  logic [31:0] line_q, line_d;
  logic        err_q, err_d;
  err_e        code_q, code_d;
  ftype_e      pend_q, pend_d;
  logic        out_valid_q, out_valid_d;
  out_beat_t   out_q;

  cls_t        c;
  logic        adv;
  logic        pop;
  out_beat_t   res;
  logic        res_valid;

  nphase_e     f_nph;
  logic        f_neg;
  logic        f_acc_en;
  logic        f_hex;
  logic [67:0] f_mul;
  logic [67:0] f_sum;
  logic        f_ovf;
  logic [63:0] f_acc;
  logic        feed;
  ftype_e      unq_type;

  logic        cl_req;
  ftype_e      cl_type;
  logic        cl_last;
  logic        cl_eof;
  logic        key_new;
  logic [16:0] cnt_next;
  logic [63:0] cl_val;
  logic        err_req;
  err_e        err_code;

  assign c           = q_data_i;
  assign adv         = !out_valid_q || !out_stall_i;
  assign pop         = q_valid_i && adv;
  assign q_pop_o     = pop;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign unq_type    = ((nph_q == NP_ZERO) || (nph_q == NP_DEC) || (nph_q == NP_HEX) ||
                        (nph_q == NP_TRAIL)) ? FT_INT : FT_TEXT;

  // number recogniser for one unquoted character
  always_comb begin
    f_nph    = nph_q;
    f_neg    = neg_q;
    f_acc_en = 1'b0;
    f_hex    = 1'b0;
    case (nph_q)
      NP_LEAD, NP_SIGN: begin
        if ((nph_q == NP_LEAD) && c.is_ws) begin
          f_nph = NP_LEAD;
        end else if ((nph_q == NP_LEAD) && c.is_plus) begin
          f_nph = NP_SIGN;
        end else if ((nph_q == NP_LEAD) && c.is_minus) begin
          f_neg = 1'b1;
          f_nph = NP_SIGN;
        end else if (c.is_zero) begin
          f_nph = NP_ZERO;
        end else if (c.is_dig) begin
          f_acc_en = 1'b1;
          f_nph    = NP_DEC;
        end else begin
          f_nph = NP_BAD;
        end
      end
      NP_ZERO: begin
        if (c.is_x) begin
          f_nph = NP_HEXP;
        end else if (c.is_dig) begin
          f_acc_en = 1'b1;
          f_nph    = NP_DEC;
        end else if (c.is_ws) begin
          f_nph = NP_TRAIL;
        end else begin
          f_nph = NP_BAD;
        end
      end
      NP_HEXP: begin
        if (c.hex_ok) begin
          f_acc_en = 1'b1;
          f_hex    = 1'b1;
          f_nph    = NP_HEX;
        end else begin
          f_nph = NP_BAD;
        end
      end
      NP_DEC: begin
        if (c.is_dig) begin
          f_acc_en = 1'b1;
        end else if (c.is_ws) begin
          f_nph = NP_TRAIL;
        end else begin
          f_nph = NP_BAD;
        end
      end
      NP_HEX: begin
        if (c.hex_ok) begin
          f_acc_en = 1'b1;
          f_hex    = 1'b1;
        end else if (c.is_ws) begin
          f_nph = NP_TRAIL;
        end else begin
          f_nph = NP_BAD;
        end
      end
      NP_TRAIL: begin
        if (!c.is_ws) begin
          f_nph = NP_BAD;
        end
      end
      default: begin
        f_nph = NP_BAD;
      end
    endcase
    f_mul = f_hex ? {acc_q, 4'b0} : ({1'b0, acc_q, 3'b0} + {3'b0, acc_q, 1'b0});
    f_sum = f_mul + {64'b0, c.hex_val};
    f_ovf = ovf_q || (f_sum[67:64] != 4'b0);
    f_acc = f_ovf ? '1 : f_sum[63:0];
  end

  always_comb begin
    phase_d     = phase_q;
    nph_d       = nph_q;
    acc_d       = acc_q;
    neg_d       = neg_q;
    ovf_d       = ovf_q;
    fc_d        = fc_q;
    exp_set_d   = exp_set_q;
    exp_d       = exp_q;
    key_d       = key_q;
    line_d      = line_q;
    err_d       = err_q;
    code_d      = code_q;
    pend_d      = pend_q;
    res         = '0;
    res_valid   = 1'b0;
    feed        = 1'b0;
    cl_req      = 1'b0;
    cl_type     = FT_EMPTY;
    cl_last     = 1'b0;
    cl_eof      = 1'b0;
    err_req     = 1'b0;
    err_code    = ERR_NON_ASCII;
    key_new     = key_q;
    cnt_next    = {1'b0, fc_q} + 17'd1;
    cl_val      = '0;

    if (pop) begin
      if (err_q) begin
        res_valid        = 1'b1;
        res.result_kind  = RK_ERROR;
        res.error_code   = code_q;
      end else if (phase_q == PH_DONE) begin
        res_valid = 1'b0;
      end else if (c.eof) begin
        case (phase_q)
          PH_REC: begin
            res_valid       = 1'b1;
            res.result_kind = RK_STREAM;
            phase_d         = PH_DONE;
          end
          PH_FLD: begin
            res_valid          = 1'b1;
            res.result_kind    = RK_STREAM;
            res.record_dropped = 1'b1;
            fc_d               = '0;
            phase_d            = PH_DONE;
          end
          PH_UNQ: begin
            cl_req  = 1'b1;
            cl_type = unq_type;
            cl_last = 1'b1;
            cl_eof  = 1'b1;
          end
          PH_QSEEN: begin
            cl_req  = 1'b1;
            cl_type = FT_TEXT;
            cl_last = 1'b1;
            cl_eof  = 1'b1;
          end
          PH_QUO: begin
            err_req  = 1'b1;
            err_code = ERR_EOF_QUOTE;
          end
          default: begin
            err_req  = 1'b1;
            err_code = ERR_CR_NO_LF;
          end
        endcase
      end else if (c.non_ascii) begin
        err_req  = 1'b1;
        err_code = ERR_NON_ASCII;
      end else begin
        if (c.is_lf) begin
          line_d = line_q + 32'd1;
        end
        case (phase_q)
          PH_REC, PH_FLD: begin
            if (c.is_comma) begin
              cl_req  = 1'b1;
              cl_type = FT_EMPTY;
            end else if (c.is_lf) begin
              cl_req  = 1'b1;
              cl_type = FT_EMPTY;
              cl_last = 1'b1;
            end else if (c.is_cr) begin
              pend_d  = FT_EMPTY;
              phase_d = PH_CR;
            end else if (c.is_quote) begin
              phase_d = PH_QUO;
            end else begin
              phase_d = PH_UNQ;
              feed    = 1'b1;
            end
          end
          PH_UNQ: begin
            if (c.is_comma) begin
              cl_req  = 1'b1;
              cl_type = unq_type;
            end else if (c.is_lf) begin
              cl_req  = 1'b1;
              cl_type = unq_type;
              cl_last = 1'b1;
            end else if (c.is_cr) begin
              pend_d  = unq_type;
              phase_d = PH_CR;
            end else begin
              feed = 1'b1;
            end
          end
          PH_QUO: begin
            if (c.is_quote) begin
              phase_d = PH_QSEEN;
            end else begin
              res_valid        = 1'b1;
              res.result_kind  = RK_CONTENT;
              res.content_byte = c.ch;
            end
          end
          PH_QSEEN: begin
            if (c.is_quote) begin
              phase_d          = PH_QUO;
              res_valid        = 1'b1;
              res.result_kind  = RK_CONTENT;
              res.content_byte = c.ch;
            end else if (c.is_comma) begin
              cl_req  = 1'b1;
              cl_type = FT_TEXT;
            end else if (c.is_lf) begin
              cl_req  = 1'b1;
              cl_type = FT_TEXT;
              cl_last = 1'b1;
            end else if (c.is_cr) begin
              pend_d  = FT_TEXT;
              phase_d = PH_CR;
            end else begin
              err_req  = 1'b1;
              err_code = ERR_STRAY;
            end
          end
          PH_CR: begin
            if (c.is_lf) begin
              cl_req  = 1'b1;
              cl_type = pend_q;
              cl_last = 1'b1;
            end else begin
              err_req  = 1'b1;
              err_code = ERR_CR_NO_LF;
            end
          end
          default: begin
            res_valid = 1'b0;
          end
        endcase
      end
    end

    if (feed) begin
      nph_d            = f_nph;
      neg_d            = f_neg;
      res_valid        = 1'b1;
      res.result_kind  = RK_CONTENT;
      res.content_byte = c.ch;
      if (f_acc_en) begin
        acc_d = f_acc;
        ovf_d = f_ovf;
      end
    end

    if (cl_req) begin
      cl_val  = (cl_type == FT_INT) ? (neg_q ? (64'd0 - acc_q) : acc_q) : 64'd0;
      key_new = (fc_q == '0) ? (cl_type == FT_INT) : key_q;
      key_d   = key_new;
      if (cl_last) begin
        if (!exp_set_q) begin
          exp_set_d = 1'b1;
          exp_d     = cnt_next[15:0];
        end
        if (exp_set_q && ({1'b0, exp_q} != cnt_next)) begin
          err_req  = 1'b1;
          err_code = ERR_LEN_MISMATCH;
        end else if (!key_new) begin
          err_req  = 1'b1;
          err_code = ERR_KEY_NOT_INT;
        end else begin
          res_valid          = 1'b1;
          res.result_kind    = cl_eof ? RK_STREAM : RK_FIELD;
          res.field_type     = cl_type;
          res.int_value      = cl_val;
          res.field_index    = fc_q;
          res.last_in_record = 1'b1;
          fc_d               = '0;
          phase_d            = cl_eof ? PH_DONE : PH_REC;
        end
      end else begin
        if (cnt_next >= MaxFields) begin
          err_req  = 1'b1;
          err_code = ERR_TOO_MANY;
        end else begin
          res_valid       = 1'b1;
          res.result_kind = RK_FIELD;
          res.field_type  = cl_type;
          res.int_value   = cl_val;
          res.field_index = fc_q;
          fc_d            = cnt_next[15:0];
          phase_d         = PH_FLD;
        end
      end
      if (!err_req) begin
        nph_d = NP_LEAD;
        acc_d = '0;
        neg_d = 1'b0;
        ovf_d = 1'b0;
      end
    end

    if (err_req) begin
      err_d           = 1'b1;
      code_d          = err_code;
      res             = '0;
      res_valid       = 1'b1;
      res.result_kind = RK_ERROR;
      res.error_code  = err_code;
    end

    res.line_number = line_d;
    out_valid_d     = adv ? (pop && res_valid) : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_REC;
      nph_q       <= NP_LEAD;
      acc_q       <= '0;
      neg_q       <= 1'b0;
      ovf_q       <= 1'b0;
      fc_q        <= '0;
      exp_set_q   <= 1'b0;
      exp_q       <= '0;
      key_q       <= 1'b0;
      line_q      <= '0;
      err_q       <= 1'b0;
      code_q      <= ERR_NON_ASCII;
      pend_q      <= FT_EMPTY;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      nph_q       <= nph_d;
      acc_q       <= acc_d;
      neg_q       <= neg_d;
      ovf_q       <= ovf_d;
      fc_q        <= fc_d;
      exp_set_q   <= exp_set_d;
      exp_q       <= exp_d;
      key_q       <= key_d;
      line_q      <= line_d;
      err_q       <= err_d;
      code_q      <= code_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= res;
    end
  end

  `CSV_ASSERT_NXT(a_err_sticky, err_q, err_q && $stable(code_q) && $stable(line_q), "error state left")
  `CSV_ASSERT_IMP(a_done_silent, (phase_q == PH_DONE) && !err_q, !res_valid, "result after stream end")
  `CSV_ASSERT_ALWAYS(a_fc_bound, {1'b0, fc_q} < MaxFields, "field counter beyond limit")
  `CSV_ASSERT_NXT(a_line_step, 1'b1, (line_q == $past(line_q)) || (line_q == $past(line_q) + 32'd1), "line counter jump")

endmodule

// ----- design/csv_record_tokenizer_core.sv -----
// CSV record tokenizer: one file byte per beat in, one result per beat out at most.
// The block takes one byte beat every cycle unless the queue is full. The input
// classifier writes a two-entry queue; the parser consumes one queued beat per cycle
// into the result register while the output is not stalled, a sustained rate of one
// byte per cycle, updating its phase, number recogniser and 64-bit multiply-by-ten or
// sixteen accumulator per byte. A stall on the result side holds the parser; the queue
// then fills and stalls the input once it holds two beats. No clearing pass follows
// reset. The first error is latched and repeated for every later beat; after the
// stream end beat further input beats are taken and give no result.
module csv_record_tokenizer_core #(
  parameter int unsigned MAX_FIELDS = 65535
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  csv_rt_pkg::in_beat_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output csv_rt_pkg::out_beat_t out_data_o
);
  import csv_rt_pkg::*;

  logic q_full;
  logic q_push;
  cls_t q_wdata;
  logic q_pop;
  logic q_valid;
  cls_t q_rdata;

  csv_rt_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_wdata)
  );

  csv_rt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_rdata)
  );

  csv_rt_back #(
    .MAX_FIELDS (MAX_FIELDS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_rdata),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
